@@ sv/i2a_pkg.sv @@
package i2a_pkg;

    // default depth of the digit store
    localparam int MAX_DIGITS_DEF = 10;

    // reciprocal of ten: q = (v * RECIP_TEN) >> RECIP_SHIFT for any 32-bit v
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_LOWER = 7'h61;

    typedef enum logic [1:0] {
        MODE_SDEC = 2'd0,
        MODE_UDEC = 2'd1,
        MODE_HEXL = 2'd2,
        MODE_HEXU = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SUB,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_sub;
        logic hex_step;
        logic start_emit;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic work_zero;
        logic cnt_full;
        logic is_dec;
        logic neg;
        logic idx_zero;
        logic out_free;
    } sts_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'd0, d};
        end else if (upper) begin
            c = CHAR_UPPER + {3'd0, d} - 7'd10;
        end else begin
            c = CHAR_LOWER + {3'd0, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

@@ sv/i2a_ctrl.sv @@
module i2a_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  i2a_pkg::sts_t sts,
    output i2a_pkg::cmd_t cmd
);

    i2a_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_valid) state_next = i2a_pkg::ST_CONV;
            end
            i2a_pkg::ST_CONV: begin
                if (sts.work_zero || sts.cnt_full) begin
                    state_next = sts.neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIGIT;
                end else if (sts.is_dec) begin
                    state_next = i2a_pkg::ST_SUB;
                end
            end
            i2a_pkg::ST_SUB: begin
                state_next = i2a_pkg::ST_CONV;
            end
            i2a_pkg::ST_SIGN: begin
                if (sts.out_free) state_next = i2a_pkg::ST_DIGIT;
            end
            i2a_pkg::ST_DIGIT: begin
                if (sts.out_free && sts.idx_zero) state_next = i2a_pkg::ST_IDLE;
            end
            default: state_next = i2a_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            i2a_pkg::ST_CONV: begin
                if (sts.work_zero || sts.cnt_full) begin
                    cmd.start_emit = 1'b1;
                end else if (sts.is_dec) begin
                    cmd.mul = 1'b1;
                end else begin
                    cmd.hex_step = 1'b1;
                end
            end
            i2a_pkg::ST_SUB: begin
                cmd.div_sub = 1'b1;
            end
            i2a_pkg::ST_SIGN: begin
                cmd.emit_sign = sts.out_free;
            end
            i2a_pkg::ST_DIGIT: begin
                cmd.emit_digit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/i2a_dp.sv @@
module i2a_dp #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    s_action,
    input  logic [31:0]   s_word_value,
    input  logic          m_ready,
    output logic          m_valid,
    output logic [6:0]    m_char_code,
    output logic          m_last_char,
    output logic [3:0]    m_text_length,
    input  i2a_pkg::cmd_t cmd,
    output i2a_pkg::sts_t sts
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [31:0]      work_reg;
    logic [31:0]      quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             neg_reg;
    i2a_pkg::mode_t   mode_reg;
    logic [3:0]       digit_mem [MAX_DIGITS];

    logic             m_valid_reg;
    logic [6:0]       m_char_reg;
    logic             m_last_reg;
    logic [3:0]       m_len_reg;

    logic             in_neg;
    logic [31:0]      in_mag;
    logic [63:0]      product;
    logic [31:0]      rem_full;
    logic [CNT_W:0]   total;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [3:0]       wr_data;

    assign in_neg  = (i2a_pkg::mode_t'(s_action) == i2a_pkg::MODE_SDEC) && s_word_value[31];
    assign in_mag  = in_neg ? (32'd0 - s_word_value) : s_word_value;
    assign product = {32'd0, work_reg} * {32'd0, i2a_pkg::RECIP_TEN};
    // remainder from the registered quotient: work - 10*q
    assign rem_full = work_reg - {quot_reg[28:0], 3'b000} - {quot_reg[30:0], 1'b0};
    assign total    = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, neg_reg};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[IDX_W-1:0];
        wr_data = 4'd0;
        priority if (cmd.load) begin
            wr_en   = (in_mag == 32'd0);
            wr_addr = '0;
            wr_data = 4'd0;
        end else if (cmd.div_sub) begin
            wr_en   = 1'b1;
            wr_data = rem_full[3:0];
        end else if (cmd.hex_step) begin
            wr_en   = 1'b1;
            wr_data = work_reg[3:0];
        end else begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) digit_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= '0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            mode_reg <= i2a_pkg::MODE_SDEC;
        end else begin
            if (cmd.load) begin
                work_reg <= in_mag;
                neg_reg  <= in_neg;
                mode_reg <= i2a_pkg::mode_t'(s_action);
                cnt_reg  <= (in_mag == 32'd0) ? CNT_W'(1) : '0;
            end else if (cmd.div_sub) begin
                work_reg <= quot_reg;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end else if (cmd.hex_step) begin
                work_reg <= {4'd0, work_reg[31:4]};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) quot_reg <= {3'd0, product[63:i2a_pkg::RECIP_SHIFT]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_emit) begin
            idx_reg <= IDX_W'(cnt_reg - CNT_W'(1));
        end else if (cmd.emit_digit) begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            m_char_reg <= i2a_pkg::CHAR_MINUS;
            m_last_reg <= 1'b0;
            m_len_reg  <= 4'd0;
        end else if (cmd.emit_digit) begin
            m_char_reg <= i2a_pkg::digit_char(digit_mem[idx_reg],
                                              mode_reg == i2a_pkg::MODE_HEXU);
            m_last_reg <= (idx_reg == '0);
            m_len_reg  <= (idx_reg == '0) ? total[3:0] : 4'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_char_code   = m_char_reg;
    assign m_last_char   = m_last_reg;
    assign m_text_length = m_len_reg;

    assign sts.work_zero = (work_reg == 32'd0);
    assign sts.cnt_full  = (cnt_reg == CNT_W'(MAX_DIGITS));
    assign sts.is_dec    = (mode_reg == i2a_pkg::MODE_SDEC) || (mode_reg == i2a_pkg::MODE_UDEC);
    assign sts.neg       = neg_reg;
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count past store depth");

    a_last_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_len_reg != 4'd0)
        else $error("final character without length");

    a_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sign |=> m_valid_reg && !m_last_reg && m_char_reg == i2a_pkg::CHAR_MINUS)
        else $error("sign character not followed by digits");

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_emit |-> cnt_reg != '0)
        else $error("emission started with no digits");

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// integer to ascii formatter: one input transaction carries a 2-bit format
// (signed decimal, unsigned decimal, lowercase hex, uppercase hex) and a 32-bit
// word; the block answers with one output transaction per character, most
// significant first, with a leading '-' for negative signed values (the most
// negative value prints exactly) and a single '0' for zero. the final character
// raises m_last_char and carries the total character count in m_text_length,
// which reads 0 on every other character. sequence: the word is taken in idle,
// then each decimal digit takes a reciprocal multiply step, then a remainder
// and store step, and each hex digit a single shift step; a start-emission step
// follows, then one character per cycle while the output side takes them.
// the next word is taken as soon as the last character sits in the output
// register, even if it has not been taken yet.
module integer_to_ascii_formatter #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_word_value,
    // output transaction, one per character
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_char_code,
    output logic        m_last_char,
    output logic [3:0]  m_text_length
);

    // command and status between sequencer and datapath
    i2a_pkg::cmd_t cmd;
    i2a_pkg::sts_t sts;

    // sequencer: load, per-digit conversion steps, then character emission
    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: magnitude, divide-by-ten unit, digit store, output register
    i2a_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_word_value  (s_word_value),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_char_code   (m_char_code),
        .m_last_char   (m_last_char),
        .m_text_length (m_text_length),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
